// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the contact force block.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define DCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define DCF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/core/dcf_pkg.sv
// Package of the contact force block: word types, constants, arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps

package dcf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int FMAX_W      = 63 - FRAC_BITS;
    localparam int SQRT_STAGES = 16;
    localparam int SQRT_STEPS  = 2;
    localparam int DIV_STAGES  = 32;
    localparam int DIV_STEPS   = 2;
    localparam int PRE_STAGES  = 6;
    localparam int ST_S7       = PRE_STAGES + SQRT_STAGES;
    localparam int ST_S8       = ST_S7 + 1;
    localparam int PIPE_DEPTH  = ST_S8 + 1 + 2 * DIV_STAGES + 1;
    localparam int CFG_IDX_W   = 2;

    localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic [31:0] MAG_MIN = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KN = 2'd0,
        CFG_KS = 2'd1,
        CFG_MU = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_overlap;
        logic signed [31:0] normal_vel_x;
        logic signed [31:0] normal_vel_y;
        logic signed [31:0] shear_vel_x;
        logic signed [31:0] shear_vel_y;
        logic signed [31:0] shear_overlap_x;
        logic signed [31:0] shear_overlap_y;
        logic [30:0]        damping;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] normal_force_x;
        logic signed [31:0] normal_force_y;
        logic signed [31:0] shear_force_x;
        logic signed [31:0] shear_force_y;
        logic signed [31:0] new_shear_overlap_x;
        logic signed [31:0] new_shear_overlap_y;
        logic               sliding;
    } t_out_word;

    // Per-contact data carried alongside the long arithmetic units.
    typedef struct packed {
        logic signed [31:0] fnx;
        logic signed [31:0] fny;
        logic signed [31:0] fsx;
        logic signed [31:0] fsy;
        logic signed [31:0] sox;
        logic signed [31:0] soy;
        logic               slide;
        logic               ekover;
    } t_side;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sq_state;

    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] dq;
        logic [31:0] d;
    } t_div_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > SAT_HI) res = SAT_HI[31:0];
        else if (v < SAT_LO) res = SAT_LO[31:0];
        else res = v[31:0];
        return res;
    endfunction

    // Floor shift of a raw product, then saturate.
    function automatic logic signed [31:0] fx_fin(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> FRAC_BITS;
        return sat32(s);
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] res;
        res = v[31] ? 32'(-v) : 32'(v);
        return res;
    endfunction

    // One digit of the bitwise integer square root.
    function automatic t_sq_state sqrt_step(input t_sq_state s, input int it);
        logic [63:0] b;
        logic [63:0] t;
        b = 64'd1 << (62 - 2 * it);
        t = s.r + b;
        if (s.v >= t) begin
            s.v = s.v - t;
            s.r = (s.r >> 1) + b;
        end else begin
            s.r = s.r >> 1;
        end
        return s;
    endfunction

    // One quotient bit of restoring division.
    function automatic t_div_state div_step(input t_div_state s);
        logic [32:0] t;
        logic        q;
        t = {s.rem, s.dq[63]};
        q = 1'b0;
        if (t >= {1'b0, s.d}) begin
            t = t - {1'b0, s.d};
            q = 1'b1;
        end
        s.rem = t[31:0];
        s.dq  = {s.dq[62:0], q};
        return s;
    endfunction

    // Shear overlap from the capped force: -fsc / ks, saturated.
    function automatic logic signed [31:0] ovl_from(input logic signed [31:0] fsc,
                                                    input logic [63:0] q);
        logic [31:0]        qm;
        logic signed [31:0] res;
        qm = (q > 64'(MAG_MIN)) ? MAG_MIN : q[31:0];
        if (fsc == 32'sd0) res = 32'sd0;
        else if (fsc > 32'sd0) res = 32'(-$signed(qm));
        else res = qm[31] ? S32_MAX : $signed(qm);
        return res;
    endfunction

endpackage

// File: rtl/core/dcf_if.sv
// Channel interfaces of the contact force block: input, result and register write.
// Depends on dcf_pkg.
`timescale 1ns / 1ps

interface dcf_in_if import dcf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

interface dcf_out_if import dcf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

interface dcf_cfg_if import dcf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/dcf_isqrt.sv
// Pipelined 64-bit integer square root, two digits per stage.
// Depends on dcf_pkg.
`timescale 1ns / 1ps

module dcf_isqrt import dcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_value,
    output logic [31:0] o_root
);

    t_sq_state r_st [SQRT_STAGES];
    t_sq_state n_st [SQRT_STAGES];

    always_comb begin
        t_sq_state src;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            src = (k == 0) ? '{v: i_value, r: 64'd0} : r_st[(k == 0) ? 0 : k - 1];
            for (int j = 0; j < SQRT_STEPS; j++) begin
                src = sqrt_step(src, k * SQRT_STEPS + j);
            end
            n_st[k] = src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_root = r_st[SQRT_STAGES-1].r[31:0];

endmodule

// File: rtl/core/dcf_div.sv
// Pipelined 64 by 32 bit unsigned restoring divider, two quotient bits per stage.
// Depends on dcf_pkg.
`timescale 1ns / 1ps

module dcf_div import dcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic [63:0] o_quotient
);

    t_div_state r_st [DIV_STAGES];
    t_div_state n_st [DIV_STAGES];

    always_comb begin
        t_div_state src;
        for (int k = 0; k < DIV_STAGES; k++) begin
            src = (k == 0) ? '{rem: 32'd0, dq: i_dividend, d: i_divisor}
                           : r_st[(k == 0) ? 0 : k - 1];
            for (int j = 0; j < DIV_STEPS; j++) begin
                src = div_step(src);
            end
            n_st[k] = src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_quotient = r_st[DIV_STAGES-1].dq;

endmodule

// File: rtl/core/dem_contact_force_with_friction.sv
// Top level of the 2D spring-dashpot contact force kernel with Coulomb friction.
// Depends on dcf_pkg, dcf_if, dcf_isqrt, dcf_div and assert_macros.svh.
//
// Use: one contact word enters on i_in, one force word leaves on o_out, both
// valid/ready. Stiffnesses and friction coefficient are written on i_cfg
// (index 0 kn, 1 ks, 2 mu); write them only while the pipeline is empty.
// Throughput: one contact per cycle while o_out is not stalled, bursts of
// any length. Depth: 89 register stages. The stages are six multiply/saturate
// stages, the 16-stage square root, two friction-limit stages, the 32-stage
// divider that scales the force, the 32-stage divider that rebuilds the shear
// overlap, and the output register. All stages advance together; when o_out
// is stalled with a word held, the whole pipeline freezes and i_in.ready
// drops in the same cycle, so nothing is lost or repeated. Bubbles stay in
// place and are not squeezed out. Reset (synchronous, active low) empties
// the pipeline and restores kn = 1.0, ks = 1.0, mu = 0.5. The register port
// is always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dem_contact_force_with_friction import dcf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dcf_in_if.sink   i_in,
    dcf_out_if.source o_out,
    dcf_cfg_if.sink  i_cfg
);

    // Configuration registers
    logic [30:0] r_kn, r_ks, r_mu;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kn <= 31'd65536;
            r_ks <= 31'd65536;
            r_mu <= 31'd32768;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KN:  r_kn <= i_cfg.data[30:0];
                CFG_KS:  r_ks <= i_cfg.data[30:0];
                CFG_MU:  r_mu <= i_cfg.data[30:0];
                default: ;
            endcase
        end
    end

    // Global advance: the output word is gone or being taken.
    logic                  w_adv;
    logic                  w_acc;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign w_adv      = !r_vld[PIPE_DEPTH-1] || o_out.ready;
    assign w_acc      = i_in.valid && w_adv;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_acc};
        end
    end

    // Stage 1: raw products
    logic signed [63:0] r_s1_pkov, r_s1_pekx, r_s1_peky;
    logic signed [63:0] r_s1_pdnx, r_s1_pdny, r_s1_pdsx, r_s1_pdsy;
    logic signed [31:0] r_s1_nx, r_s1_ny, r_s1_sox, r_s1_soy;
    // Stage 2: floored, saturated products
    logic signed [31:0] r_s2_kov, r_s2_ekx, r_s2_eky, r_s2_dnx, r_s2_dny;
    logic signed [31:0] r_s2_dsx, r_s2_dsy, r_s2_nx, r_s2_ny, r_s2_sox, r_s2_soy;
    // Stage 3: normal projection products, shear force sums
    logic signed [63:0] r_s3_pnx, r_s3_pny;
    logic signed [31:0] r_s3_dnx, r_s3_dny, r_s3_fsx, r_s3_fsy;
    logic signed [31:0] r_s3_enx, r_s3_eny, r_s3_sox, r_s3_soy;
    // Stage 4: forces
    t_side              r_s4_side;
    logic signed [31:0] r_s4_enx, r_s4_eny;
    // Stage 5: squares
    t_side              r_s5_side;
    logic [63:0]        r_s5_qnx, r_s5_qny, r_s5_qsx, r_s5_qsy, r_s5_qex, r_s5_qey;
    // Stage 6: squared lengths
    t_side              r_s6_side;
    logic [63:0]        r_s6_sn, r_s6_ss, r_s6_se;
    // Square root stages
    t_side              r_sq_side [SQRT_STAGES];
    logic [31:0]        w_len_n, w_len_s, w_len_e;
    // Stage 7: friction limit product
    t_side              r_s7_side;
    logic [62:0]        r_s7_pmax;
    logic [31:0]        r_s7_lens, r_s7_lene;
    // Stage 8: slide decision, scaling dividends
    t_side              r_s8_side;
    t_side              n_s8_side;
    logic [31:0]        r_s8_lens;
    logic [63:0]        r_s8_dx, r_s8_dy;
    logic [FMAX_W-1:0]  w_fmax;
    // Dividers
    t_side              r_d1_side [DIV_STAGES];
    t_side              r_d2_side [DIV_STAGES];
    t_side              w_d2_in;
    logic [63:0]        w_q1x, w_q1y, w_q2x, w_q2y;
    t_side              w_last;
    t_out_word          r_out;

    dcf_isqrt u_sqrt_n (.i_clk, .i_en(w_adv), .i_value(r_s6_sn), .o_root(w_len_n));
    dcf_isqrt u_sqrt_s (.i_clk, .i_en(w_adv), .i_value(r_s6_ss), .o_root(w_len_s));
    dcf_isqrt u_sqrt_e (.i_clk, .i_en(w_adv), .i_value(r_s6_se), .o_root(w_len_e));

    assign w_fmax = r_s7_pmax[62:FRAC_BITS];

    // Slide when the shear length beats the limit; flag an elastic part over it too.
    always_comb begin
        n_s8_side        = r_s7_side;
        n_s8_side.slide  = FMAX_W'(r_s7_lens) > w_fmax;
        n_s8_side.ekover = FMAX_W'(r_s7_lene) > w_fmax;
    end

    // Capped force magnitude: |fs| * fmax / |fs_len|.
    dcf_div u_div_fx (.i_clk, .i_en(w_adv), .i_dividend(r_s8_dx),
                      .i_divisor(r_s8_lens), .o_quotient(w_q1x));
    dcf_div u_div_fy (.i_clk, .i_en(w_adv), .i_dividend(r_s8_dy),
                      .i_divisor(r_s8_lens), .o_quotient(w_q1y));

    // Swap in the capped force when sliding.
    always_comb begin
        w_d2_in = r_d1_side[DIV_STAGES-1];
        if (w_d2_in.slide) begin
            w_d2_in.fsx = w_d2_in.fsx[31] ? 32'(-$signed(w_q1x[31:0])) : $signed(w_q1x[31:0]);
            w_d2_in.fsy = w_d2_in.fsy[31] ? 32'(-$signed(w_q1y[31:0])) : $signed(w_q1y[31:0]);
        end
    end

    // Overlap reset magnitude: (|fsc| << FRAC_BITS) / ks.
    dcf_div u_div_ox (.i_clk, .i_en(w_adv), .i_dividend(64'(w_q1x[31:0]) << FRAC_BITS),
                      .i_divisor({1'b0, r_ks}), .o_quotient(w_q2x));
    dcf_div u_div_oy (.i_clk, .i_en(w_adv), .i_dividend(64'(w_q1y[31:0]) << FRAC_BITS),
                      .i_divisor({1'b0, r_ks}), .o_quotient(w_q2y));

    assign w_last = r_d2_side[DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // Stage 1
            r_s1_pkov <= $signed({1'b0, r_kn}) * i_in.data.normal_overlap;
            r_s1_pekx <= i_in.data.shear_overlap_x * $signed({1'b0, r_ks});
            r_s1_peky <= i_in.data.shear_overlap_y * $signed({1'b0, r_ks});
            r_s1_pdnx <= i_in.data.normal_vel_x * $signed({1'b0, i_in.data.damping});
            r_s1_pdny <= i_in.data.normal_vel_y * $signed({1'b0, i_in.data.damping});
            r_s1_pdsx <= i_in.data.shear_vel_x * $signed({1'b0, i_in.data.damping});
            r_s1_pdsy <= i_in.data.shear_vel_y * $signed({1'b0, i_in.data.damping});
            r_s1_nx   <= i_in.data.normal_x;
            r_s1_ny   <= i_in.data.normal_y;
            r_s1_sox  <= i_in.data.shear_overlap_x;
            r_s1_soy  <= i_in.data.shear_overlap_y;
            // Stage 2
            r_s2_kov <= fx_fin(r_s1_pkov);
            r_s2_ekx <= fx_fin(r_s1_pekx);
            r_s2_eky <= fx_fin(r_s1_peky);
            r_s2_dnx <= fx_fin(r_s1_pdnx);
            r_s2_dny <= fx_fin(r_s1_pdny);
            r_s2_dsx <= fx_fin(r_s1_pdsx);
            r_s2_dsy <= fx_fin(r_s1_pdsy);
            r_s2_nx  <= r_s1_nx;
            r_s2_ny  <= r_s1_ny;
            r_s2_sox <= r_s1_sox;
            r_s2_soy <= r_s1_soy;
            // Stage 3
            r_s3_pnx <= r_s2_nx * r_s2_kov;
            r_s3_pny <= r_s2_ny * r_s2_kov;
            r_s3_dnx <= r_s2_dnx;
            r_s3_dny <= r_s2_dny;
            r_s3_fsx <= sat32(-64'(r_s2_ekx) - 64'(r_s2_dsx));
            r_s3_fsy <= sat32(-64'(r_s2_eky) - 64'(r_s2_dsy));
            r_s3_enx <= sat32(-64'(r_s2_ekx));
            r_s3_eny <= sat32(-64'(r_s2_eky));
            r_s3_sox <= r_s2_sox;
            r_s3_soy <= r_s2_soy;
            // Stage 4
            r_s4_side.fnx    <= sat32(-64'(fx_fin(r_s3_pnx)) - 64'(r_s3_dnx));
            r_s4_side.fny    <= sat32(-64'(fx_fin(r_s3_pny)) - 64'(r_s3_dny));
            r_s4_side.fsx    <= r_s3_fsx;
            r_s4_side.fsy    <= r_s3_fsy;
            r_s4_side.sox    <= r_s3_sox;
            r_s4_side.soy    <= r_s3_soy;
            r_s4_side.slide  <= 1'b0;
            r_s4_side.ekover <= 1'b0;
            r_s4_enx         <= r_s3_enx;
            r_s4_eny         <= r_s3_eny;
            // Stage 5
            r_s5_side <= r_s4_side;
            r_s5_qnx  <= 64'(r_s4_side.fnx * r_s4_side.fnx);
            r_s5_qny  <= 64'(r_s4_side.fny * r_s4_side.fny);
            r_s5_qsx  <= 64'(r_s4_side.fsx * r_s4_side.fsx);
            r_s5_qsy  <= 64'(r_s4_side.fsy * r_s4_side.fsy);
            r_s5_qex  <= 64'(r_s4_enx * r_s4_enx);
            r_s5_qey  <= 64'(r_s4_eny * r_s4_eny);
            // Stage 6
            r_s6_side <= r_s5_side;
            r_s6_sn   <= r_s5_qnx + r_s5_qny;
            r_s6_ss   <= r_s5_qsx + r_s5_qsy;
            r_s6_se   <= r_s5_qex + r_s5_qey;
            // Square root side line
            r_sq_side[0] <= r_s6_side;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
            // Stage 7
            r_s7_side <= r_sq_side[SQRT_STAGES-1];
            r_s7_pmax <= r_mu * w_len_n;
            r_s7_lens <= w_len_s;
            r_s7_lene <= w_len_e;
            // Stage 8
            r_s8_side        <= n_s8_side;
            r_s8_lens        <= r_s7_lens;
            r_s8_dx          <= abs32(r_s7_side.fsx) * w_fmax[31:0];
            r_s8_dy          <= abs32(r_s7_side.fsy) * w_fmax[31:0];
            // Divider side lines
            r_d1_side[0] <= r_s8_side;
            r_d2_side[0] <= w_d2_in;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_d1_side[k] <= r_d1_side[k-1];
                r_d2_side[k] <= r_d2_side[k-1];
            end
            // Output register
            r_out.normal_force_x <= w_last.fnx;
            r_out.normal_force_y <= w_last.fny;
            r_out.shear_force_x  <= w_last.fsx;
            r_out.shear_force_y  <= w_last.fsy;
            r_out.new_shear_overlap_x <= (w_last.slide && w_last.ekover)
                                         ? ovl_from(w_last.fsx, w_q2x) : w_last.sox;
            r_out.new_shear_overlap_y <= (w_last.slide && w_last.ekover)
                                         ? ovl_from(w_last.fsy, w_q2y) : w_last.soy;
            r_out.sliding <= w_last.slide;
        end
    end

    assign o_out.valid = r_vld[PIPE_DEPTH-1];
    assign o_out.data  = r_out;

    `DCF_ASSERT(a_stall_freezes, !w_adv |=> $stable(r_vld), "pipeline moved during a stall")
    `DCF_ASSERT(a_scale_divisor, r_vld[ST_S8] && r_s8_side.slide |-> r_s8_lens != '0, "zero divisor")
    `DCF_ASSERT_RST(a_reset_empties, !i_rst_n |=> !o_out.valid, "result valid right after reset")

endmodule
